// ===== sv/o2ps_pkg.sv =====
package o2ps_pkg;

	localparam int CORR_WIDTH    = 48;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ACC_W         = 64;
	localparam int HALF_W        = ACC_W / 2;
	localparam int WIDE_W        = 2 * ACC_W + 1;
	localparam int COEFF_W       = 20;
	localparam int SHIFT_W       = 5;
	localparam int APB_W         = 32;
	localparam int ADDR_W        = 3;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);
	localparam logic REG_THRESHOLD_SHIFT = 1'b0;

	typedef enum logic [1:0] {
		OUT_FULL  = 2'd0,
		OUT_FIRST = 2'd1,
		OUT_ZERO  = 2'd2
	} outcome_t;

	typedef struct packed {
		logic        [CORR_WIDTH-2:0] energy_current;
		logic signed [CORR_WIDTH-1:0] cross_current_first;
		logic        [CORR_WIDTH-2:0] energy_first;
		logic signed [CORR_WIDTH-1:0] cross_current_second;
		logic signed [CORR_WIDTH-1:0] cross_first_second;
		logic        [CORR_WIDTH-2:0] energy_second;
	} item_t;

	typedef struct packed {
		logic signed [COEFF_W-1:0] coeff_first;
		logic signed [COEFF_W-1:0] coeff_second;
		outcome_t                  solve_outcome;
		logic                      clipped;
	} result_t;

	typedef struct packed {
		logic        [ACC_W-1:0] c;
		logic signed [ACC_W-1:0] b;
		logic        [ACC_W-1:0] eps;
		logic                    pivot;
		logic                    zero;
	} ctx1_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] x1;
		logic signed [ACC_W-1:0] b1;
		logic                    pivot;
		logic                    zero;
		logic                    fb;
		logic                    clip_fb;
		logic                    clip_y2;
	} ctx2_t;

endpackage

// ===== sv/o2ps_div.sv =====
module o2ps_div #(
	parameter int NUM_W = 80,
	parameter int SB_W  = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [NUM_W-1:0]               in_num,
	input  logic [o2ps_pkg::ACC_W-1:0]     in_den,
	input  logic                           in_neg,
	input  logic [SB_W-1:0]                in_sb,
	output logic                           out_valid,
	output logic signed [o2ps_pkg::ACC_W-1:0] out_quot,
	output logic                           out_clip,
	output logic [SB_W-1:0]                out_sb
);
	import o2ps_pkg::*;

	logic [ACC_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [ACC_W-1:0] den_s [NUM_W];
	logic             neg_s [NUM_W];
	logic [SB_W-1:0]  sb_s  [NUM_W];
	logic             v_s   [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [ACC_W-1:0] rem_p;
		logic [ACC_W-1:0] den_p;
		logic [NUM_W-1:0] nq_p;
		logic             neg_p;
		logic             v_p;
		logic [SB_W-1:0]  sb_p;
		logic [ACC_W:0]   trial;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_p = '0;
			assign den_p = in_den;
			assign nq_p  = in_num;
			assign neg_p = in_neg;
			assign v_p   = in_valid;
			assign sb_p  = in_sb;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign nq_p  = nq_s[k-1];
			assign neg_p = neg_s[k-1];
			assign v_p   = v_s[k-1];
			assign sb_p  = sb_s[k-1];
		end

		assign trial = {rem_p, nq_p[NUM_W-1]};
		assign take  = trial >= {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? ACC_W'(trial - {1'b0, den_p}) : trial[ACC_W-1:0];
				nq_s[k]  <= {nq_p[NUM_W-2:0], take};
				den_s[k] <= den_p;
				neg_s[k] <= neg_p;
				sb_s[k]  <= sb_p;
			end
		end
	end

	logic [NUM_W-1:0] q_mag;
	logic             over;
	logic [ACC_W-1:0] q_sat;

	assign q_mag = nq_s[NUM_W-1];

	always_comb begin
		if (neg_s[NUM_W-1]) begin
			over  = (|q_mag[NUM_W-1:ACC_W]) || (q_mag[ACC_W-1] && (|q_mag[ACC_W-2:0]));
			q_sat = over ? {1'b1, {(ACC_W-1){1'b0}}} : ACC_W'(-q_mag[ACC_W-1:0]);
		end else begin
			over  = |q_mag[NUM_W-1:ACC_W-1];
			q_sat = over ? {1'b0, {(ACC_W-1){1'b1}}} : q_mag[ACC_W-1:0];
		end
	end

	logic                    v_sn;
	logic signed [ACC_W-1:0] quot_sn;
	logic                    clip_sn;
	logic [SB_W-1:0]         sb_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else if (en) begin
			v_sn <= v_s[NUM_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_sn <= q_sat;
			clip_sn <= over;
			sb_sn   <= sb_s[NUM_W-1];
		end
	end

	assign out_valid = v_sn;
	assign out_quot  = quot_sn;
	assign out_clip  = clip_sn;
	assign out_sb    = sb_sn;

endmodule

// ===== sv/order2_predictor_solver_top.sv =====
// Second-order predictor solver. Each transfer on the item channel carries the upper
// triangle of a 3x3 autocorrelation matrix; exactly one result transfer follows, in
// order, with both coefficients (FRAC_BITS fraction bits), the solve outcome and a
// saturation flag. One item is accepted per cycle while no result is stalled. The
// two radix-2 dividers run in series (one quotient bit per stage, 64 + FRAC_BITS
// stages each), with pipelined multiply and subtract stages around them. A stalled
// result freezes the whole pipeline. threshold_shift sits at byte address 0.
module order2_predictor_solver_top #(
	parameter int FRAC_BITS = o2ps_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  o2ps_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output o2ps_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [o2ps_pkg::ADDR_W-1:0]   paddr,
	input  logic [o2ps_pkg::APB_W-1:0]    pwdata,
	output logic [o2ps_pkg::APB_W-1:0]    prdata,
	output logic                          pready
);
	import o2ps_pkg::*;

	localparam int NUM_W = ACC_W + FRAC_BITS;

	function automatic logic [ACC_W:0] sat_acc(input logic signed [WIDE_W-1:0] v);
		logic over;
		over = !((&v[WIDE_W-1:ACC_W-1]) || !(|v[WIDE_W-1:ACC_W-1]));
		if (!over) begin
			return {1'b0, v[ACC_W-1:0]};
		end
		return v[WIDE_W-1] ? {1'b1, 1'b1, {(ACC_W-1){1'b0}}} : {1'b1, 1'b0, {(ACC_W-1){1'b1}}};
	endfunction

	function automatic logic [COEFF_W:0] sat_coeff(input logic signed [WIDE_W-1:0] v);
		logic over;
		over = !((&v[WIDE_W-1:COEFF_W-1]) || !(|v[WIDE_W-1:COEFF_W-1]));
		if (!over) begin
			return {1'b0, v[COEFF_W-1:0]};
		end
		return v[WIDE_W-1] ? {2'b11, {(COEFF_W-1){1'b0}}} : {2'b10, {(COEFF_W-1){1'b1}}};
	endfunction

	function automatic logic [ACC_W-1:0] mag_of(input logic signed [ACC_W-1:0] v);
		return v[ACC_W-1] ? ACC_W'(-v) : v;
	endfunction

	function automatic logic [2*ACC_W-1:0] sum_pp(input logic [ACC_W-1:0] p00,
		input logic [ACC_W-1:0] p01, input logic [ACC_W-1:0] p10,
		input logic [ACC_W-1:0] p11);
		return {{ACC_W{1'b0}}, p00} + {{HALF_W{1'b0}}, p01, {HALF_W{1'b0}}}
			+ {{HALF_W{1'b0}}, p10, {HALF_W{1'b0}}} + {p11, {ACC_W{1'b0}}};
	endfunction

	logic en;
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	// config
	logic [SHIFT_W-1:0] shift_q;
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_THRESHOLD_SHIFT) ? APB_W'(shift_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SHIFT_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[ADDR_W-1] == REG_THRESHOLD_SHIFT) begin
			shift_q <= pwdata[SHIFT_W-1:0];
		end
	end

	// s1: decode, threshold, pivot
	logic        [ACC_W-1:0] r0, r2, r5, maxv, a_c, c_c;
	logic signed [ACC_W-1:0] r1, r3, r4;
	logic signed [ACC_W:0]   xa, ya;
	logic                    piv_c;

	always_comb begin
		r0 = ACC_W'(item.energy_current);
		r2 = ACC_W'(item.energy_first);
		r5 = ACC_W'(item.energy_second);
		r1 = ACC_W'(item.cross_current_first);
		r3 = ACC_W'(item.cross_current_second);
		r4 = ACC_W'(item.cross_first_second);
		maxv = r0;
		if (r2 > maxv) maxv = r2;
		if (r5 > maxv) maxv = r5;
		piv_c = r5 > r2;
		xa = -((ACC_W+1)'(r1));
		ya = -((ACC_W+1)'(r3));
		a_c = piv_c ? r5 : r2;
		c_c = piv_c ? r2 : r5;
	end

	logic                    v_s1, pivot_s1;
	logic        [ACC_W-1:0] a_s1, c_s1, eps_s1;
	logic signed [ACC_W-1:0] b_s1;
	logic signed [ACC_W:0]   x_s1, y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= a_c;
			c_s1     <= c_c;
			b_s1     <= r4;
			eps_s1   <= maxv >> shift_q;
			pivot_s1 <= piv_c;
			x_s1     <= piv_c ? ya : xa;
			y_s1     <= piv_c ? xa : ya;
		end
	end

	// first division pair: b1 = b/a, x1 = x/a
	ctx1_t            ctx1_in, ctx1_d;
	logic [ACC_W-1:0] x_mag;
	logic             v1a, v1b, b1_clip, x1_clip;
	logic signed [ACC_W-1:0] b1_d, x1_d;
	logic [ACC_W:0]   y_d;

	assign x_mag   = x_s1[ACC_W] ? ACC_W'(-x_s1) : x_s1[ACC_W-1:0];
	assign ctx1_in = '{c: c_s1, b: b_s1, eps: eps_s1, pivot: pivot_s1, zero: a_s1 <= eps_s1};

	o2ps_div #(.NUM_W(NUM_W), .SB_W($bits(ctx1_t))) u_div_b1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.in_num(NUM_W'(mag_of(b_s1)) << FRAC_BITS), .in_den(a_s1),
		.in_neg(b_s1[ACC_W-1]), .in_sb(ctx1_in),
		.out_valid(v1a), .out_quot(b1_d), .out_clip(b1_clip), .out_sb(ctx1_d)
	);

	o2ps_div #(.NUM_W(NUM_W), .SB_W(ACC_W+1)) u_div_x1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.in_num(NUM_W'(x_mag) << FRAC_BITS), .in_den(a_s1),
		.in_neg(x_s1[ACC_W]), .in_sb(y_s1),
		.out_valid(v1b), .out_quot(x1_d), .out_clip(x1_clip), .out_sb(y_d)
	);

	// s2: partial products of b1*b and x1*b
	logic [ACC_W-1:0] m1a, m2a, mb;
	assign m1a = mag_of(b1_d);
	assign m2a = mag_of(x1_d);
	assign mb  = mag_of(ctx1_d.b);

	logic                    v_s2, clip_s2, sg1_s2, sg2_s2;
	ctx1_t                   ctx1_s2;
	logic signed [ACC_W-1:0] b1_s2, x1_s2;
	logic signed [ACC_W:0]   y_s2;
	logic [ACC_W-1:0]        pp1_s2 [4];
	logic [ACC_W-1:0]        pp2_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v1a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx1_s2   <= ctx1_d;
			b1_s2     <= b1_d;
			x1_s2     <= x1_d;
			y_s2      <= y_d;
			clip_s2   <= b1_clip | x1_clip;
			sg1_s2    <= b1_d[ACC_W-1] ^ ctx1_d.b[ACC_W-1];
			sg2_s2    <= x1_d[ACC_W-1] ^ ctx1_d.b[ACC_W-1];
			pp1_s2[0] <= m1a[HALF_W-1:0] * mb[HALF_W-1:0];
			pp1_s2[1] <= m1a[HALF_W-1:0] * mb[ACC_W-1:HALF_W];
			pp1_s2[2] <= m1a[ACC_W-1:HALF_W] * mb[HALF_W-1:0];
			pp1_s2[3] <= m1a[ACC_W-1:HALF_W] * mb[ACC_W-1:HALF_W];
			pp2_s2[0] <= m2a[HALF_W-1:0] * mb[HALF_W-1:0];
			pp2_s2[1] <= m2a[HALF_W-1:0] * mb[ACC_W-1:HALF_W];
			pp2_s2[2] <= m2a[ACC_W-1:HALF_W] * mb[HALF_W-1:0];
			pp2_s2[3] <= m2a[ACC_W-1:HALF_W] * mb[ACC_W-1:HALF_W];
		end
	end

	// s3: sum and sign
	logic [2*ACC_W-1:0] pm1, pm2;
	assign pm1 = sum_pp(pp1_s2[0], pp1_s2[1], pp1_s2[2], pp1_s2[3]);
	assign pm2 = sum_pp(pp2_s2[0], pp2_s2[1], pp2_s2[2], pp2_s2[3]);

	logic                      v_s3, clip_s3;
	ctx1_t                     ctx1_s3;
	logic signed [ACC_W-1:0]   b1_s3, x1_s3;
	logic signed [ACC_W:0]     y_s3;
	logic signed [2*ACC_W-1:0] pr1_s3, pr2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx1_s3 <= ctx1_s2;
			b1_s3   <= b1_s2;
			x1_s3   <= x1_s2;
			y_s3    <= y_s2;
			clip_s3 <= clip_s2;
			pr1_s3  <= sg1_s2 ? -pm1 : pm1;
			pr2_s3  <= sg2_s2 ? -pm2 : pm2;
		end
	end

	// s4: c2 = c - b1*b, y2 = y - x1*b
	logic signed [WIDE_W-1:0] c2w, y2w;
	logic [ACC_W:0]           c2r, y2r;

	always_comb begin
		c2w = $signed(WIDE_W'(ctx1_s3.c)) - WIDE_W'(pr1_s3 >>> FRAC_BITS);
		y2w = WIDE_W'(y_s3) - WIDE_W'(pr2_s3 >>> FRAC_BITS);
		c2r = sat_acc(c2w);
		y2r = sat_acc(y2w);
	end

	logic                    v_s4, clip_s4, clip_y2_s4;
	ctx1_t                   ctx1_s4;
	logic signed [ACC_W-1:0] b1_s4, x1_s4, c2_s4, y2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx1_s4    <= ctx1_s3;
			b1_s4      <= b1_s3;
			x1_s4      <= x1_s3;
			c2_s4      <= c2r[ACC_W-1:0];
			y2_s4      <= y2r[ACC_W-1:0];
			clip_s4    <= clip_s3 | c2r[ACC_W];
			clip_y2_s4 <= y2r[ACC_W];
		end
	end

	// s5: fallback test, divider operands
	logic [ACC_W-1:0] c2_mag;
	assign c2_mag = mag_of(c2_s4);

	logic             v_s5, neg_s5;
	logic [ACC_W-1:0] den_s5, ynum_s5;
	ctx2_t            ctx2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5  <= c2_mag;
			ynum_s5 <= mag_of(y2_s4);
			neg_s5  <= y2_s4[ACC_W-1] ^ c2_s4[ACC_W-1];
			ctx2_s5 <= '{x1: x1_s4, b1: b1_s4, pivot: ctx1_s4.pivot, zero: ctx1_s4.zero,
				fb: c2_mag <= ctx1_s4.eps, clip_fb: clip_s4, clip_y2: clip_y2_s4};
		end
	end

	// second division: y3 = y2/c2
	logic                    v2, y3_clip;
	logic signed [ACC_W-1:0] y3_d;
	ctx2_t                   ctx2_d;

	o2ps_div #(.NUM_W(NUM_W), .SB_W($bits(ctx2_t))) u_div_y3 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.in_num(NUM_W'(ynum_s5) << FRAC_BITS), .in_den(den_s5),
		.in_neg(neg_s5), .in_sb(ctx2_s5),
		.out_valid(v2), .out_quot(y3_d), .out_clip(y3_clip), .out_sb(ctx2_d)
	);

	// s6: partial products of y3*b1
	logic [ACC_W-1:0] m3a, m3b;
	assign m3a = mag_of(y3_d);
	assign m3b = mag_of(ctx2_d.b1);

	logic                    v_s6, clip_y3_s6, sg3_s6;
	ctx2_t                   ctx2_s6;
	logic signed [ACC_W-1:0] y3_s6;
	logic [ACC_W-1:0]        pp3_s6 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx2_s6    <= ctx2_d;
			y3_s6      <= y3_d;
			clip_y3_s6 <= y3_clip;
			sg3_s6     <= y3_d[ACC_W-1] ^ ctx2_d.b1[ACC_W-1];
			pp3_s6[0]  <= m3a[HALF_W-1:0] * m3b[HALF_W-1:0];
			pp3_s6[1]  <= m3a[HALF_W-1:0] * m3b[ACC_W-1:HALF_W];
			pp3_s6[2]  <= m3a[ACC_W-1:HALF_W] * m3b[HALF_W-1:0];
			pp3_s6[3]  <= m3a[ACC_W-1:HALF_W] * m3b[ACC_W-1:HALF_W];
		end
	end

	// s7: sum and sign
	logic [2*ACC_W-1:0] pm3;
	assign pm3 = sum_pp(pp3_s6[0], pp3_s6[1], pp3_s6[2], pp3_s6[3]);

	logic                      v_s7, clip_y3_s7;
	ctx2_t                     ctx2_s7;
	logic signed [ACC_W-1:0]   y3_s7;
	logic signed [2*ACC_W-1:0] pr3_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx2_s7    <= ctx2_s6;
			y3_s7      <= y3_s6;
			clip_y3_s7 <= clip_y3_s6;
			pr3_s7     <= sg3_s6 ? -pm3 : pm3;
		end
	end

	// s8: x4 = x1 - y3*b1, output saturation and selection
	logic signed [WIDE_W-1:0] tw;
	logic [COEFF_W:0]         x1r, tr, y3r;
	logic [COEFF_W-1:0]       cpiv, coth;
	result_t                  res_c;

	always_comb begin
		tw  = WIDE_W'(ctx2_s7.x1) - WIDE_W'(pr3_s7 >>> FRAC_BITS);
		x1r = sat_coeff(WIDE_W'(ctx2_s7.x1));
		tr  = sat_coeff(tw);
		y3r = sat_coeff(WIDE_W'(y3_s7));
		if (ctx2_s7.zero) begin
			cpiv = '0;
			coth = '0;
			res_c.solve_outcome = OUT_ZERO;
			res_c.clipped = 1'b0;
		end else if (ctx2_s7.fb) begin
			cpiv = x1r[COEFF_W-1:0];
			coth = '0;
			res_c.solve_outcome = OUT_FIRST;
			res_c.clipped = ctx2_s7.clip_fb | x1r[COEFF_W];
		end else begin
			cpiv = tr[COEFF_W-1:0];
			coth = y3r[COEFF_W-1:0];
			res_c.solve_outcome = OUT_FULL;
			res_c.clipped = ctx2_s7.clip_fb | ctx2_s7.clip_y2 | clip_y3_s7
				| tr[COEFF_W] | y3r[COEFF_W];
		end
		res_c.coeff_first  = ctx2_s7.pivot ? coth : cpiv;
		res_c.coeff_second = ctx2_s7.pivot ? cpiv : coth;
	end

	logic    v_s8;
	result_t res_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s8 <= res_c;
		end
	end

	assign result_valid = v_s8;
	assign result       = res_s8;

`ifndef SYNTHESIS
	a_div_lanes: assert property (@(posedge clk) disable iff (!arst_n) v1a == v1b)
		else $error("first divider lanes out of step");
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.solve_outcome == OUT_ZERO
		|-> !result.clipped && result.coeff_first == '0 && result.coeff_second == '0)
		else $error("zero matrix result not clean");
	a_first_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.solve_outcome == OUT_FIRST
		|-> result.coeff_first == '0 || result.coeff_second == '0)
		else $error("first-order result has two coefficients");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> $stable(v_s5) && $stable(v_s1))
		else $error("pipeline moved while stalled");
`endif

endmodule

// ===== tb/order2_predictor_solver_top_tb.sv =====
`timescale 1ns / 100ps

module order2_predictor_solver_top_tb;
	import o2ps_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LATENCY = 2 * FRAC + 138;
	localparam int STALL_LIMIT = 20000;
	localparam int N_RANDOM = 1000;
	localparam logic [ADDR_W-1:0] ADDR_SHIFT = ADDR_W'(REG_THRESHOLD_SHIFT) << 2;
	localparam logic [46:0] EMAX = {47{1'b1}};
	localparam logic signed [47:0] CMAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] CMIN = {1'b1, {47{1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b1;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_W-1:0] pwdata = '0;
	logic [APB_W-1:0] prdata;
	logic pready;

	result_t coeff_queue[$];
	logic [4:0] shift_cfg;
	int errors = 0;
	int sent = 0;
	int received = 0;
	int idle_cycles = 0;
	int n_full = 0, n_first = 0, n_zero = 0, n_clip = 0;
	logic hold_off = 1'b0;

	order2_predictor_solver_top dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic signed [128:0] sat_to(input logic signed [128:0] v, input int bits,
			inout logic clip);
		logic signed [128:0] hi, lo;
		hi = (129'sd1 <<< (bits - 1)) - 1;
		lo = -(129'sd1 <<< (bits - 1));
		if (v > hi) begin
			clip = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clip = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic result_t solve_coeffs(input item_t it, input logic [4:0] sh);
		logic signed [128:0] r1, r3, r4, a, c, x, y, tmp, b1, x1, c2, mag, y2, y3, t, eps, mx;
		logic signed [128:0] cf [2];
		logic clip;
		logic piv;
		result_t res;
		clip = 1'b0;
		r1 = it.cross_current_first;
		r3 = it.cross_current_second;
		r4 = it.cross_first_second;
		mx = $signed({82'd0, it.energy_current});
		if ($signed({82'd0, it.energy_first}) > mx) mx = $signed({82'd0, it.energy_first});
		if ($signed({82'd0, it.energy_second}) > mx) mx = $signed({82'd0, it.energy_second});
		eps = mx >>> sh;
		a = $signed({82'd0, it.energy_first});
		c = $signed({82'd0, it.energy_second});
		x = -r1;
		y = -r3;
		piv = c > a;
		if (piv) begin
			tmp = a; a = c; c = tmp;
			tmp = x; x = y; y = tmp;
		end
		res = '0;
		if (a <= eps) begin
			res.solve_outcome = OUT_ZERO;
			return res;
		end
		cf[0] = 0;
		cf[1] = 0;
		b1 = sat_to((r4 <<< FRAC) / a, 64, clip);
		x1 = sat_to((x <<< FRAC) / a, 64, clip);
		c2 = sat_to(c - ((b1 * r4) >>> FRAC), 64, clip);
		mag = c2 < 0 ? -c2 : c2;
		if (mag <= eps) begin
			cf[piv] = sat_to(x1, COEFF_W, clip);
			res.solve_outcome = OUT_FIRST;
		end else begin
			y2 = sat_to(y - ((x1 * r4) >>> FRAC), 64, clip);
			y3 = sat_to((y2 <<< FRAC) / c2, 64, clip);
			t = x1 - ((y3 * b1) >>> FRAC);
			cf[piv] = sat_to(t, COEFF_W, clip);
			cf[!piv] = sat_to(y3, COEFF_W, clip);
			res.solve_outcome = OUT_FULL;
		end
		res.coeff_first = cf[0][COEFF_W-1:0];
		res.coeff_second = cf[1][COEFF_W-1:0];
		res.clipped = clip;
		return res;
	endfunction

	task automatic apb_write(input logic [4:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_SHIFT;
		pwdata <= APB_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shift_cfg = val;
	endtask

	task automatic apb_check_read();
		@(posedge clk);
		psel <= 1'b1;
		paddr <= ADDR_SHIFT;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[4:0] !== shift_cfg) begin
			$error("threshold_shift readback: expected %0d actual %0d", shift_cfg, prdata[4:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_item(input item_t it, input logic use_fixed, input result_t fixed);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		coeff_queue.push_back(use_fixed ? fixed : solve_coeffs(it, shift_cfg));
		sent++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (coeff_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [46:0] rand_energy();
		logic [46:0] v;
		v = 47'({$urandom, $urandom});
		case ($urandom_range(0, 4))
			0: v = v >> $urandom_range(0, 46);
			1: v = EMAX;
			default: v = v >> $urandom_range(0, 20);
		endcase
		return v;
	endfunction

	function automatic logic signed [47:0] rand_cross(input logic [46:0] scale);
		logic signed [47:0] v;
		case ($urandom_range(0, 5))
			0: v = 48'({$urandom, $urandom});
			1: v = $urandom_range(0, 1) ? CMAX : CMIN;
			default: begin
				v = $signed({1'b0, scale}) >>> $urandom_range(0, 3);
				v = v - $signed({1'b0, 47'(47'({$urandom, $urandom}) % (48'(scale) + 1))});
				if ($urandom_range(0, 1)) v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		logic [46:0] s;
		it.energy_current = rand_energy();
		it.energy_first = rand_energy();
		it.energy_second = rand_energy();
		s = it.energy_first > it.energy_second ? it.energy_first : it.energy_second;
		it.cross_current_first = rand_cross(s);
		it.cross_current_second = rand_cross(s);
		it.cross_first_second = rand_cross(s);
		if ($urandom_range(0, 7) == 0) it.energy_second = it.energy_first;
		return it;
	endfunction

	// result side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (coeff_queue.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					result_t exp_r;
					exp_r = coeff_queue.pop_front();
					received++;
					case (result.solve_outcome)
						OUT_FULL: n_full++;
						OUT_FIRST: n_first++;
						default: n_zero++;
					endcase
					if (result.clipped) n_clip++;
					if (result.coeff_first !== exp_r.coeff_first) begin
						$error("coeff_first: expected %0d actual %0d",
							exp_r.coeff_first, result.coeff_first);
						errors++;
					end
					if (result.coeff_second !== exp_r.coeff_second) begin
						$error("coeff_second: expected %0d actual %0d",
							exp_r.coeff_second, result.coeff_second);
						errors++;
					end
					if (result.solve_outcome !== exp_r.solve_outcome) begin
						$error("solve_outcome: expected %0d actual %0d",
							exp_r.solve_outcome, result.solve_outcome);
						errors++;
					end
					if (result.clipped !== exp_r.clipped) begin
						$error("clipped: expected %0d actual %0d",
							exp_r.clipped, result.clipped);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				result_stall <= 1'b1;
				repeat (LATENCY + 300) @(posedge clk);
				hold_off <= 1'b0;
			end
			wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
			if (wait_n > 0) begin
				result_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("FAIL order2_predictor_solver_top");
			$finish;
		end
	end

	typedef struct {
		item_t it;
		logic fixed;
		result_t res;
	} vec_t;

	initial begin
		vec_t dir[$];
		vec_t v;
		logic [4:0] shifts[5];
		shifts = '{5'd0, 5'd31, 5'd4, 5'd20, 5'd12};
		shift_cfg = SHIFT_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_check_read();

		// zero matrix: outcome known at a glance
		v.fixed = 1'b1;
		v.res = '{coeff_first: '0, coeff_second: '0, solve_outcome: OUT_ZERO, clipped: 1'b0};
		v.it = '0; dir.push_back(v);
		v.it = '{EMAX, CMAX, 47'd0, CMIN, CMIN, 47'd0}; dir.push_back(v);
		v.it = '{EMAX, CMIN, 47'd100, CMAX, CMAX, 47'd5}; dir.push_back(v);
		v.fixed = 1'b0;
		v.it = '{47'd0, -48'sd65536, 47'd65536, 48'sd0, 48'sd0, 47'd65536}; dir.push_back(v);
		v.it = '{47'd0, CMAX, 47'd1, CMIN, CMAX, 47'd1}; dir.push_back(v);
		v.it = '{EMAX, CMAX, EMAX, CMIN, CMAX, EMAX}; dir.push_back(v);
		v.it = '{EMAX, CMIN, EMAX, CMAX, CMIN, 47'd3}; dir.push_back(v);
		v.it = '{47'd10, -48'sd1000, 47'd4000, 48'sd500, 48'sd4000, 47'd4000}; dir.push_back(v);
		v.it = '{47'd10, 48'sd1000, 47'd300, -48'sd700, -48'sd200, 47'd900}; dir.push_back(v);
		v.it = '{47'd0, 48'sd7, 47'd2, 48'sd3, 48'sd1, 47'd2}; dir.push_back(v);
		v.it = '{47'd0, -48'sd1, 47'd5000000, 48'sd1, 48'sd4999999, 47'd5000000};
		dir.push_back(v);
		v.it = '{47'd0, CMIN, 47'd1000, CMAX, 48'sd1000, 47'd1001}; dir.push_back(v);
		foreach (dir[i]) send_item(dir[i].it, dir[i].fixed, dir[i].res);
		drain();

		foreach (shifts[p]) begin
			apb_write(shifts[p]);
			apb_check_read();
			for (int k = 0; k < N_RANDOM / 5; k++) begin
				if (p == 2 && k == 20) hold_off <= 1'b1;
				send_item(rand_item(), 1'b0, '0);
			end
			drain();
		end
		$display("%0d items sent, %0d results checked, directed set plus five threshold shifts",
			sent, received);
		$display("outcomes: full %0d, first-order %0d, zero %0d; clipped %0d",
			n_full, n_first, n_zero, n_clip);
		if (errors == 0 && coeff_queue.size() == 0)
			$display("PASS order2_predictor_solver_top");
		else
			$display("FAIL order2_predictor_solver_top");
		$finish;
	end

endmodule
